// ===== design/assert_macros.svh =====
// assertion macros used by the rgb to hsv contrast top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/rthc_pkg.sv =====
// types and constants for the rgb to hsv contrast block
// no dependencies
`default_nettype none
package rthc_pkg;
  localparam int unsigned QBITS = 16;
  localparam logic [15:0] LUM_R = 16'd13933;
  localparam logic [15:0] LUM_G = 16'd46871;
  localparam logic [15:0] LUM_B = 16'd4732;
  localparam logic [25:0] LUM_HALF = 26'd16711680; // 255 * 65536

  typedef enum logic [2:0] {
    CODE_BLACK   = 3'd0,
    CODE_WHITE   = 3'd1,
    CODE_CYAN    = 3'd2,
    CODE_MAGENTA = 3'd3,
    CODE_YELLOW  = 3'd4
  } code_t;

  // payload handed from cell to cell
  typedef struct packed {
    logic [10:0] hue_rem;
    logic [10:0] hue_div;
    logic [15:0] hue_q;
    logic [7:0]  sat_rem;
    logic [7:0]  sat_div;
    logic [15:0] sat_q;
    logic        hue_zero;
    logic        sat_zero;
    logic        sat_full;
    logic [7:0]  bright;
    logic [7:0]  alpha;
    code_t       code;
  } stage_t;
endpackage
`default_nettype wire

// ===== design/rthc_front.sv =====
// front stage: max, chroma, sector offset and contrast code
// depends on rthc_pkg
`default_nettype none
module rthc_front import rthc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_vld,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic [7:0] alpha,
  output logic            vld_r,
  output stage_t          st_r
);
  logic [7:0] x, y, z, mn;
  logic [8:0] c;
  logic signed [4:0] k6;
  logic signed [13:0] h6s;
  logic [10:0] h6;
  logic [25:0] lum;
  logic sat_low;
  stage_t st_nxt;

  always_comb begin
    x = red;
    y = green;
    z = blue;
    k6 = 5'sd0;
    if (y < z) begin
      y = blue;
      z = green;
      k6 = -5'sd6;
    end
    if (x < y) begin
      y = x;
      x = (green < blue) ? blue : green;
      k6 = -5'sd2 - k6;
    end
    mn = (y < z) ? y : z;
    c = {1'b0, x} - {1'b0, mn};
    h6s = 14'(k6 * $signed({5'b0, c})) + $signed({6'b0, y}) - $signed({6'b0, z});
    h6 = (h6s < 0) ? 11'(-h6s) : 11'(h6s);
    lum = {10'b0, LUM_R} * {18'b0, red} + {10'b0, LUM_G} * {18'b0, green} +
          {10'b0, LUM_B} * {18'b0, blue};
    sat_low = ({c, 1'b0} < {2'b0, x});
    st_nxt.hue_rem = h6;
    st_nxt.hue_div = {2'b0, c} * 11'd6;
    st_nxt.hue_q = '0;
    st_nxt.sat_rem = c[7:0];
    st_nxt.sat_div = x;
    st_nxt.sat_q = '0;
    st_nxt.hue_zero = (c == 9'd0);
    st_nxt.sat_zero = (x == 8'd0);
    st_nxt.sat_full = (mn == 8'd0) && (x != 8'd0);
    st_nxt.bright = x;
    st_nxt.alpha = alpha;
    if (sat_low || x == 8'd0) begin
      st_nxt.code = ({lum, 1'b0} > {1'b0, LUM_HALF}) ? CODE_BLACK : CODE_WHITE;
    end else if ({2'b0, h6} < {4'b0, c} || {2'b0, h6} > {4'b0, c} * 13'd5) begin
      st_nxt.code = CODE_CYAN;
    end else if ({2'b0, h6} < {4'b0, c} * 13'd3) begin
      st_nxt.code = CODE_MAGENTA;
    end else begin
      st_nxt.code = CODE_YELLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end
endmodule
`default_nettype wire

// ===== design/rthc_cell.sv =====
// divider cell: one quotient bit of hue and of saturation per request
// depends on rthc_pkg
`default_nettype none
module rthc_cell import rthc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic vld_in,
  input  stage_t    st_in,
  output logic      vld_r,
  output stage_t    st_r
);
  logic [11:0] h2;
  logic [8:0]  s2;
  stage_t st_nxt;

  always_comb begin
    st_nxt = st_in;
    h2 = {st_in.hue_rem, 1'b0};
    s2 = {st_in.sat_rem, 1'b0};
    if (h2 >= {1'b0, st_in.hue_div}) begin
      st_nxt.hue_rem = 11'(h2 - {1'b0, st_in.hue_div});
      st_nxt.hue_q = {st_in.hue_q[14:0], 1'b1};
    end else begin
      st_nxt.hue_rem = h2[10:0];
      st_nxt.hue_q = {st_in.hue_q[14:0], 1'b0};
    end
    if (s2 >= {1'b0, st_in.sat_div}) begin
      st_nxt.sat_rem = 8'(s2 - {1'b0, st_in.sat_div});
      st_nxt.sat_q = {st_in.sat_q[14:0], 1'b1};
    end else begin
      st_nxt.sat_rem = s2[7:0];
      st_nxt.sat_q = {st_in.sat_q[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end
endmodule
`default_nettype wire

// ===== design/rgb_to_hsv_contrast_top.sv =====
// top level of the rgb to hsv contrast block
// depends on rthc_pkg, rthc_front, rthc_cell and assert_macros.svh
//
// usage: drive in_red, in_green, in_blue and in_alpha with start high for one
// cycle; busy is always low, so a new pixel may be issued on every clock.
// each pixel gives exactly one result, shown for one cycle with out_valid high
// on out_hue, out_saturation, out_brightness, out_alpha_out and
// out_contrast_code. results leave in request order.
// structure: one front stage for max, chroma and contrast code, then a row of
// 16 divider cells, each adding one quotient bit of hue and of saturation.
// throughput: one pixel per cycle.
// reset (rst_n low, synchronous) drops every pending request; out_valid goes
// low at the next edge. the receiver cannot stall, so nothing is held back.
// hue is a fraction of the full circle times 65536; saturation is chroma over
// maximum times 65536, limited to 65535.
`default_nettype none
`include "assert_macros.svh"
module rgb_to_hsv_contrast_top import rthc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  input  wire logic [7:0] in_alpha,
  output logic            out_valid,
  output logic [15:0]     out_hue,
  output logic [15:0]     out_saturation,
  output logic [7:0]      out_brightness,
  output logic [7:0]      out_alpha_out,
  output logic [2:0]      out_contrast_code
);
  logic   vld [QBITS+1];
  stage_t st  [QBITS+1];
  stage_t last;

  assign busy = 1'b0;

  rthc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(start && !busy),
    .red(in_red), .green(in_green), .blue(in_blue), .alpha(in_alpha),
    .vld_r(vld[0]), .st_r(st[0])
  );

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    rthc_cell u_cell (
      .clk(clk), .rst_n(rst_n), .vld_in(vld[i]), .st_in(st[i]),
      .vld_r(vld[i+1]), .st_r(st[i+1])
    );
  end

  assign last = st[QBITS];
  assign out_valid = vld[QBITS];
  assign out_hue = last.hue_zero ? 16'd0 : last.hue_q;
  assign out_saturation = last.sat_zero ? 16'd0 :
                          (last.sat_full ? 16'hFFFF : last.sat_q);
  assign out_brightness = last.bright;
  assign out_alpha_out = last.alpha;
  assign out_contrast_code = last.code;

  `ASSERT_IMPL(a_code_range, clk, rst_n, out_valid, out_contrast_code <= CODE_YELLOW)
  `ASSERT_IMPL(a_black_sat, clk, rst_n, out_valid && out_brightness == 8'd0,
    out_saturation == 16'd0 && out_hue == 16'd0)
  `ASSERT_IMPL(a_low_sat_code, clk, rst_n, out_valid && !out_saturation[15],
    out_contrast_code == CODE_BLACK || out_contrast_code == CODE_WHITE)
  `ASSERT_NEXT(a_front_vld, clk, rst_n, start, vld[0])
endmodule
`default_nettype wire
